>>> hw/rtl/dtsyn_pkg.sv
// shared constants, types and the quarter-wave sine table for the tone synthesizer
package dtsyn_pkg;

   localparam int SAMPLE_RATE  = 44100;
   localparam int SINE_BITS    = 10;
   localparam int SINE_ENTRIES = 1 << SINE_BITS;
   localparam int QUARTER      = SINE_ENTRIES / 4;
   localparam int QIDX_W       = SINE_BITS - 1;
   localparam int PHASE_W      = $clog2(SAMPLE_RATE);

   localparam int FREQ_W   = 10;
   localparam int DETUNE_W = 6;
   localparam int VOL_W    = 15;
   localparam int STEP_W   = 8;
   localparam int LEN_W    = 20;
   localparam int SAMPLE_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam int MAX_DIGITS = 3;

   localparam int WRAP_STEPS = FREQ_W;
   localparam int MUL_STEPS  = VOL_W;
   localparam int MAX_STEPS  = (MUL_STEPS > SINE_BITS)
                               ? ((MUL_STEPS > WRAP_STEPS) ? MUL_STEPS : WRAP_STEPS)
                               : ((SINE_BITS > WRAP_STEPS) ? SINE_BITS : WRAP_STEPS);
   localparam int CNT_W      = $clog2(MAX_STEPS);

   localparam logic [PHASE_W:0] RATE_K = (PHASE_W + 1)'(SAMPLE_RATE);

   localparam logic [FREQ_W-1:0]   FREQ_LOW_RST    = 10'd200;
   localparam logic [FREQ_W-1:0]   FREQ_HIGH_RST   = 10'd600;
   localparam logic [DETUNE_W-1:0] DETUNE_RST      = 6'd3;
   localparam logic [VOL_W-1:0]    VOL_TOP_RST     = 15'd32000;
   localparam logic [VOL_W-1:0]    VOL_FLOOR_RST   = 15'd1000;
   localparam logic [STEP_W-1:0]   VOL_STEP_RST    = 8'd2;
   localparam logic [LEN_W-1:0]    NOTE_LENGTH_RST = 20'd88200;

   localparam logic [VOL_W-1:0] VOL_MAX = '1;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FREQ_LOW    = 3'd0,
      CSR_FREQ_HIGH   = 3'd1,
      CSR_DETUNE      = 3'd2,
      CSR_VOL_TOP     = 3'd3,
      CSR_VOL_FLOOR   = 3'd4,
      CSR_VOL_STEP    = 3'd5,
      CSR_NOTE_LENGTH = 3'd6
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_WRAP   = 6'b000010,
      ST_INDEX  = 6'b000100,
      ST_LOOKUP = 6'b001000,
      ST_MULT   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   localparam longint Q30 = 64'sd1 << 30;

   // sin(pi/2 * u), u and result in Q30, odd degree-9 polynomial
   function automatic longint quarter_sine(longint u);
      longint u2;
      longint p;
      u2 = (u * u) / Q30;
      p  = 64'sd172272;
      p  = -64'sd5026995 + (p * u2) / Q30;
      p  = 64'sd85569306 + (p * u2) / Q30;
      p  = -64'sd693598669 + (p * u2) / Q30;
      p  = 64'sd1686629713 + (p * u2) / Q30;
      p  = (p * u) / Q30;
      if (p < 0) p = 0;
      if (p > Q30) p = Q30;
      return p;
   endfunction

   typedef logic [VOL_W-1:0] sine_mag_type;
   typedef sine_mag_type sine_tab_type [QUARTER+1];

   function automatic sine_mag_type sine_mag(int k);
      longint u;
      longint m;
      longint e;
      u = longint'(k) << (32 - SINE_BITS);
      m = quarter_sine(u);
      e = (m * 64'sd32768 + Q30 / 2) / Q30;
      if (e > 64'sd32767) e = 64'sd32767;
      return sine_mag_type'(e);
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      for (int k = 0; k <= QUARTER; k++) begin
         tab[k] = sine_mag(k);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

>>> hw/rtl/decimal_tone_synth_with_envelope.sv
// tone synthesizer: decimal note parser, phase accumulators, sine lookup and envelope
//
// req channel: one word per received byte (req_command 0, req_rx_byte) or per
// sample tick (req_command 1). a newline wraps the parsed digits into the
// frequency window and starts a note; each tick during a note gives one rsp word
// (rsp_sample, rsp_last marks the final sample of the note).
// csr port: write csr_wdata into register csr_index while csr_we is high; only
// while the block is idle.
// work per word: a byte other than newline is taken in idle; a newline then runs
// the bit-serial modulo by the frequency range (skipped when freq_high < freq_low);
// a tick during a note runs the phase-to-index divide by the sample rate, one
// quotient bit a cycle, then a table read, a 15-step shift-add multiply of volume
// by sine magnitude and a final step that loads the rsp register.
// a tick while no note plays is taken in idle and gives no word.
// one word is worked on at a time; req_ready is high only between words.
// a finished sample sits in the rsp register, so a new word is taken while the
// receiver stalls; a second sample waits in its last step until the register frees.
// reset (synchronous) restores register defaults, clears parser and note state,
// sets volume to 32000 with the envelope falling and empties the rsp register.
module decimal_tone_synth_with_envelope (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dtsyn_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [dtsyn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dtsyn_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int FW = dtsyn_pkg::FREQ_W;
   localparam int PW = dtsyn_pkg::PHASE_W;
   localparam int VW = dtsyn_pkg::VOL_W;
   localparam int SB = dtsyn_pkg::SINE_BITS;
   localparam int LW = dtsyn_pkg::LEN_W;
   localparam int CW = dtsyn_pkg::CNT_W;

   dtsyn_pkg::state_type state_ff, state_in;

   logic [FW-1:0]                   freq_low_ff, freq_low_in;
   logic [FW-1:0]                   freq_high_ff, freq_high_in;
   logic [dtsyn_pkg::DETUNE_W-1:0]  detune_ff, detune_in;
   logic [VW-1:0]                   vol_top_ff, vol_top_in;
   logic [VW-1:0]                   vol_floor_ff, vol_floor_in;
   logic [dtsyn_pkg::STEP_W-1:0]    vol_step_ff, vol_step_in;
   logic [LW-1:0]                   note_length_ff, note_length_in;

   logic [FW-1:0] digit_value_ff, digit_value_in;
   logic [1:0]    digit_count_ff, digit_count_in;
   logic          parse_stopped_ff, parse_stopped_in;
   logic [FW-1:0] note_freq_ff, note_freq_in;
   logic [PW-1:0] phase_main_ff, phase_main_in;
   logic [PW-1:0] phase_det_ff, phase_det_in;
   logic [LW-1:0] sample_index_ff, sample_index_in;
   logic          note_active_ff, note_active_in;
   logic [VW-1:0] volume_ff, volume_in;
   logic          rising_ff, rising_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // working registers of the serial units and the result register
   logic [FW:0]     wrap_rem_ff, wrap_rem_in;
   logic [FW-1:0]   wrap_mag_ff, wrap_mag_in;
   logic [FW:0]     wrap_range_ff, wrap_range_in;
   logic            wrap_neg_ff, wrap_neg_in;
   logic [PW-1:0]   div_rem_ff, div_rem_in;
   logic [SB-1:0]   idx_ff, idx_in;
   logic [2*VW-1:0] mul_ff, mul_in;
   logic            sine_neg_ff, sine_neg_in;
   logic [dtsyn_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic            rsp_last_ff, rsp_last_in;

   logic                 req_take;
   logic                 out_free;
   logic [FW+1:0]        wrap_trial;
   logic [FW:0]          wrap_rem_next;
   logic [FW:0]          wrap_d;
   logic [PW:0]          div_trial;
   logic                 div_ge;
   logic [SB-3:0]        quad_pos;
   logic [dtsyn_pkg::QIDX_W-1:0] tab_k;
   logic [VW:0]          mul_sum;
   logic [VW-1:0]        prod_mag;
   logic [LW-1:0]        index_next;
   logic                 is_last;
   logic [PW:0]          pm_sum;
   logic [PW:0]          pd_sum;
   logic [VW:0]          vol_up;

   assign req_ready  = (state_ff == dtsyn_pkg::ST_IDLE);
   assign req_take   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = $signed(rsp_sample_ff);
   assign rsp_last   = rsp_last_ff;

   // restoring step of the frequency-range modulo
   assign wrap_trial    = {wrap_rem_ff, wrap_mag_ff[FW-1]};
   assign wrap_rem_next = (wrap_trial >= {1'b0, wrap_range_ff})
                          ? (FW + 1)'(wrap_trial - {1'b0, wrap_range_ff})
                          : wrap_trial[FW:0];
   assign wrap_d        = (wrap_neg_ff && (wrap_rem_next != '0))
                          ? (wrap_range_ff - wrap_rem_next) : wrap_rem_next;

   // one quotient bit of phase * entries / rate
   assign div_trial = {div_rem_ff, 1'b0};
   assign div_ge    = (div_trial >= dtsyn_pkg::RATE_K);

   // quarter-wave fold of the table index
   assign quad_pos = idx_ff[SB-3:0];
   assign tab_k    = idx_ff[SB-2]
                     ? ((dtsyn_pkg::QIDX_W)'(dtsyn_pkg::QUARTER) - {1'b0, quad_pos})
                     : {1'b0, quad_pos};

   // shift-add multiply, multiplier bits leave at the bottom
   assign mul_sum  = {1'b0, mul_ff[2*VW-1:VW]} + (mul_ff[0] ? {1'b0, volume_ff} : '0);
   assign prod_mag = mul_ff[2*VW-1:VW];

   assign index_next = sample_index_ff + 1'b1;
   assign is_last    = (index_next == note_length_ff);
   assign pm_sum     = {1'b0, phase_main_ff} + (PW + 1)'(note_freq_ff);
   assign pd_sum     = {1'b0, phase_det_ff} + (PW + 1)'(note_freq_ff)
                       + (PW + 1)'(detune_ff);
   assign vol_up     = {1'b0, volume_ff} + (VW + 1)'(vol_step_ff);

   always_comb begin
      state_in         = state_ff;
      freq_low_in      = freq_low_ff;
      freq_high_in     = freq_high_ff;
      detune_in        = detune_ff;
      vol_top_in       = vol_top_ff;
      vol_floor_in     = vol_floor_ff;
      vol_step_in      = vol_step_ff;
      note_length_in   = note_length_ff;
      digit_value_in   = digit_value_ff;
      digit_count_in   = digit_count_ff;
      parse_stopped_in = parse_stopped_ff;
      note_freq_in     = note_freq_ff;
      phase_main_in    = phase_main_ff;
      phase_det_in     = phase_det_ff;
      sample_index_in  = sample_index_ff;
      note_active_in   = note_active_ff;
      volume_in        = volume_ff;
      rising_in        = rising_ff;
      cnt_in           = cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      wrap_rem_in      = wrap_rem_ff;
      wrap_mag_in      = wrap_mag_ff;
      wrap_range_in    = wrap_range_ff;
      wrap_neg_in      = wrap_neg_ff;
      div_rem_in       = div_rem_ff;
      idx_in           = idx_ff;
      mul_in           = mul_ff;
      sine_neg_in      = sine_neg_ff;
      rsp_sample_in    = rsp_sample_ff;
      rsp_last_in      = rsp_last_ff;

      if (csr_we) begin
         case (dtsyn_pkg::csr_index_type'(csr_index))
            dtsyn_pkg::CSR_FREQ_LOW:    freq_low_in    = csr_wdata[FW-1:0];
            dtsyn_pkg::CSR_FREQ_HIGH:   freq_high_in   = csr_wdata[FW-1:0];
            dtsyn_pkg::CSR_DETUNE:      detune_in      = csr_wdata[dtsyn_pkg::DETUNE_W-1:0];
            dtsyn_pkg::CSR_VOL_TOP:     vol_top_in     = csr_wdata[VW-1:0];
            dtsyn_pkg::CSR_VOL_FLOOR:   vol_floor_in   = csr_wdata[VW-1:0];
            dtsyn_pkg::CSR_VOL_STEP:    vol_step_in    = csr_wdata[dtsyn_pkg::STEP_W-1:0];
            dtsyn_pkg::CSR_NOTE_LENGTH: note_length_in = csr_wdata[LW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         dtsyn_pkg::ST_IDLE: begin
            if (req_take) begin
               if (!req_command) begin
                  if (req_rx_byte == dtsyn_pkg::CHAR_NEWLINE) begin
                     digit_value_in   = '0;
                     digit_count_in   = '0;
                     parse_stopped_in = 1'b0;
                     phase_main_in    = '0;
                     phase_det_in     = '0;
                     sample_index_in  = '0;
                     note_active_in   = 1'b1;
                     if (freq_high_ff < freq_low_ff) begin
                        note_freq_in = freq_low_ff;
                     end else begin
                        wrap_range_in = {1'b0, freq_high_ff} - {1'b0, freq_low_ff} + 1'b1;
                        wrap_neg_in   = (digit_value_ff < freq_low_ff);
                        wrap_mag_in   = (digit_value_ff < freq_low_ff)
                                        ? (freq_low_ff - digit_value_ff)
                                        : (digit_value_ff - freq_low_ff);
                        wrap_rem_in   = '0;
                        cnt_in        = CW'(dtsyn_pkg::WRAP_STEPS - 1);
                        state_in      = dtsyn_pkg::ST_WRAP;
                     end
                  end else if ((req_rx_byte >= dtsyn_pkg::CHAR_ZERO) &&
                               (req_rx_byte <= dtsyn_pkg::CHAR_NINE)) begin
                     if (!parse_stopped_ff &&
                         (digit_count_ff != 2'(dtsyn_pkg::MAX_DIGITS))) begin
                        // value * 10 + digit, low nibble of the ascii code is the digit
                        digit_value_in = FW'({digit_value_ff, 3'b000}
                                             + {2'b00, digit_value_ff, 1'b0}
                                             + (FW + 3)'(req_rx_byte[3:0]));
                        digit_count_in = digit_count_ff + 1'b1;
                     end
                  end else begin
                     parse_stopped_in = 1'b1;
                  end
               end else if (note_active_ff) begin
                  div_rem_in = sample_index_ff[0] ? phase_det_ff : phase_main_ff;
                  idx_in     = '0;
                  cnt_in     = CW'(SB - 1);
                  state_in   = dtsyn_pkg::ST_INDEX;
               end
            end
         end

         dtsyn_pkg::ST_WRAP: begin
            wrap_rem_in = wrap_rem_next;
            wrap_mag_in = {wrap_mag_ff[FW-2:0], 1'b0};
            if (cnt_ff == '0) begin
               note_freq_in = FW'({1'b0, freq_low_ff} + wrap_d);
               state_in     = dtsyn_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end

         dtsyn_pkg::ST_INDEX: begin
            div_rem_in = div_ge ? PW'(div_trial - dtsyn_pkg::RATE_K) : div_trial[PW-1:0];
            idx_in     = {idx_ff[SB-2:0], div_ge};
            if (cnt_ff == '0) begin
               state_in = dtsyn_pkg::ST_LOOKUP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end

         dtsyn_pkg::ST_LOOKUP: begin
            mul_in      = {{VW{1'b0}}, dtsyn_pkg::SINE_TAB[tab_k]};
            sine_neg_in = idx_ff[SB-1];
            cnt_in      = CW'(dtsyn_pkg::MUL_STEPS - 1);
            state_in    = dtsyn_pkg::ST_MULT;
         end

         dtsyn_pkg::ST_MULT: begin
            mul_in = {mul_sum, mul_ff[VW-1:1]};
            if (cnt_ff == '0) begin
               state_in = dtsyn_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end

         dtsyn_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sine_neg_ff ? -{1'b0, prod_mag} : {1'b0, prod_mag};
               rsp_last_in   = is_last;
               // envelope moves after every odd sample
               if (sample_index_ff[0]) begin
                  if (!rising_ff) begin
                     if (volume_ff > vol_floor_ff) begin
                        volume_in = (volume_ff >= VW'(vol_step_ff))
                                    ? (volume_ff - VW'(vol_step_ff)) : '0;
                     end else begin
                        rising_in = 1'b1;
                     end
                  end else begin
                     if (volume_ff < vol_top_ff) begin
                        volume_in = vol_up[VW] ? dtsyn_pkg::VOL_MAX : vol_up[VW-1:0];
                     end else begin
                        rising_in = 1'b0;
                     end
                  end
               end
               phase_main_in   = (pm_sum >= dtsyn_pkg::RATE_K)
                                 ? PW'(pm_sum - dtsyn_pkg::RATE_K) : pm_sum[PW-1:0];
               phase_det_in    = (pd_sum >= dtsyn_pkg::RATE_K)
                                 ? PW'(pd_sum - dtsyn_pkg::RATE_K) : pd_sum[PW-1:0];
               sample_index_in = index_next;
               if (is_last) begin
                  note_active_in = 1'b0;
               end
               state_in = dtsyn_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dtsyn_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= dtsyn_pkg::ST_IDLE;
         freq_low_ff      <= dtsyn_pkg::FREQ_LOW_RST;
         freq_high_ff     <= dtsyn_pkg::FREQ_HIGH_RST;
         detune_ff        <= dtsyn_pkg::DETUNE_RST;
         vol_top_ff       <= dtsyn_pkg::VOL_TOP_RST;
         vol_floor_ff     <= dtsyn_pkg::VOL_FLOOR_RST;
         vol_step_ff      <= dtsyn_pkg::VOL_STEP_RST;
         note_length_ff   <= dtsyn_pkg::NOTE_LENGTH_RST;
         digit_value_ff   <= '0;
         digit_count_ff   <= '0;
         parse_stopped_ff <= 1'b0;
         note_freq_ff     <= '0;
         phase_main_ff    <= '0;
         phase_det_ff     <= '0;
         sample_index_ff  <= '0;
         note_active_ff   <= 1'b0;
         volume_ff        <= dtsyn_pkg::VOL_TOP_RST;
         rising_ff        <= 1'b0;
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         freq_low_ff      <= freq_low_in;
         freq_high_ff     <= freq_high_in;
         detune_ff        <= detune_in;
         vol_top_ff       <= vol_top_in;
         vol_floor_ff     <= vol_floor_in;
         vol_step_ff      <= vol_step_in;
         note_length_ff   <= note_length_in;
         digit_value_ff   <= digit_value_in;
         digit_count_ff   <= digit_count_in;
         parse_stopped_ff <= parse_stopped_in;
         note_freq_ff     <= note_freq_in;
         phase_main_ff    <= phase_main_in;
         phase_det_ff     <= phase_det_in;
         sample_index_ff  <= sample_index_in;
         note_active_ff   <= note_active_in;
         volume_ff        <= volume_in;
         rising_ff        <= rising_in;
         cnt_ff           <= cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wrap_rem_ff   <= wrap_rem_in;
      wrap_mag_ff   <= wrap_mag_in;
      wrap_range_ff <= wrap_range_in;
      wrap_neg_ff   <= wrap_neg_in;
      div_rem_ff    <= div_rem_in;
      idx_ff        <= idx_in;
      mul_ff        <= mul_in;
      sine_neg_ff   <= sine_neg_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // phases stay reduced modulo the sample rate
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, phase_main_ff} < dtsyn_pkg::RATE_K) && ({1'b0, phase_det_ff} < dtsyn_pkg::RATE_K))
      else $error("phase accumulator out of range");

   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_command && !note_active_ff) |=> (state_ff == dtsyn_pkg::ST_IDLE))
      else $error("tick without a note started work");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == dtsyn_pkg::ST_FINISH) && out_free)
      |=> (rsp_valid_ff && (state_ff == dtsyn_pkg::ST_IDLE)))
      else $error("finished sample not loaded into rsp register");

   a_note_end: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(note_active_ff)) |-> (rsp_valid_ff && rsp_last_ff))
      else $error("note ended without a last sample");

endmodule
